[rtl/hps_pkg.sv]
package hps_pkg;

  // Width of the phase wait counter
  localparam int unsigned TIMER_W = 24;
  localparam int unsigned CFG_W   = 24;
  localparam int unsigned DUTY_W  = 8;
  localparam int unsigned DIV_W   = 16;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  // Register reset values
  localparam logic [CFG_W-1:0]  RST_POWERON  = CFG_W'(120000);
  localparam logic [CFG_W-1:0]  RST_BOOT     = CFG_W'(1800000);
  localparam logic [CFG_W-1:0]  RST_SHUTDOWN = CFG_W'(1400000);
  localparam logic [CFG_W-1:0]  RST_STOP     = CFG_W'(40000);
  localparam logic [DUTY_W-1:0] RST_DUTY_MAX = DUTY_W'(200);
  localparam logic [DUTY_W-1:0] RST_DUTY_MIN = DUTY_W'(1);
  localparam logic [DIV_W-1:0]  RST_DIVIDER  = DIV_W'(15);

  typedef enum logic [2:0] {
    PH_POWERON  = 3'd0,
    PH_BOOT     = 3'd1,
    PH_RUN      = 3'd2,
    PH_SHUTDOWN = 3'd3,
    PH_STOP     = 3'd4,
    PH_OFF      = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    CMD_PIN  = 2'd0,
    CMD_STEP = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_POWERON  = 3'd0,
    REG_BOOT     = 3'd1,
    REG_SHUTDOWN = 3'd2,
    REG_STOP     = 3'd3,
    REG_DUTY_MAX = 3'd4,
    REG_DUTY_MIN = 3'd5,
    REG_DIVIDER  = 3'd6,
    REG_NONE     = 3'd7
  } reg_idx_t;

  // Configuration as seen by the sequencer core
  typedef struct packed {
    logic [CFG_W-1:0]  poweron_ticks;
    logic [CFG_W-1:0]  boot_ticks;
    logic [CFG_W-1:0]  shutdown_ticks;
    logic [CFG_W-1:0]  stop_ticks;
    logic [DUTY_W-1:0] duty_max;
    logic [DUTY_W-1:0] duty_min;
    logic [DIV_W-1:0]  divider;
    logic              poweron_load;   // poweron_ticks written this cycle
    logic [CFG_W-1:0]  poweron_wdata;
  } cfg_t;

  // Outputs of one result item
  typedef struct packed {
    logic [2:0]        phase;
    logic [DUTY_W-1:0] duty;
    logic              breathing;
    logic              led_two;
    logic              led_one;
    logic              power_enable;
  } result_t;

endpackage

[rtl/hps_cfg.sv]
module hps_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [hps_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [hps_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [hps_pkg::DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready,
  output hps_pkg::cfg_t              cfg
);
  import hps_pkg::*;

  logic [CFG_W-1:0]  poweron_r, boot_r, shutdown_r, stop_r;
  logic [DUTY_W-1:0] duty_max_r, duty_min_r;
  logic [DIV_W-1:0]  divider_r;
  logic              wr_en;
  reg_idx_t          idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign idx        = reg_idx_t'(cfg_paddr[ADDR_W-1:2]);

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poweron_r  <= RST_POWERON;
      boot_r     <= RST_BOOT;
      shutdown_r <= RST_SHUTDOWN;
      stop_r     <= RST_STOP;
      duty_max_r <= RST_DUTY_MAX;
      duty_min_r <= RST_DUTY_MIN;
      divider_r  <= RST_DIVIDER;
    end else if (wr_en) begin
      case (idx)
        REG_POWERON:  poweron_r  <= cfg_pwdata[CFG_W-1:0];
        REG_BOOT:     boot_r     <= cfg_pwdata[CFG_W-1:0];
        REG_SHUTDOWN: shutdown_r <= cfg_pwdata[CFG_W-1:0];
        REG_STOP:     stop_r     <= cfg_pwdata[CFG_W-1:0];
        REG_DUTY_MAX: duty_max_r <= cfg_pwdata[DUTY_W-1:0];
        REG_DUTY_MIN: duty_min_r <= cfg_pwdata[DUTY_W-1:0];
        REG_DIVIDER:  divider_r  <= cfg_pwdata[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_POWERON:  cfg_prdata = DATA_W'(poweron_r);
      REG_BOOT:     cfg_prdata = DATA_W'(boot_r);
      REG_SHUTDOWN: cfg_prdata = DATA_W'(shutdown_r);
      REG_STOP:     cfg_prdata = DATA_W'(stop_r);
      REG_DUTY_MAX: cfg_prdata = DATA_W'(duty_max_r);
      REG_DUTY_MIN: cfg_prdata = DATA_W'(duty_min_r);
      REG_DIVIDER:  cfg_prdata = DATA_W'(divider_r);
      default:      cfg_prdata = '0;
    endcase
  end

  // Present settings to the core
  always_comb begin
    cfg.poweron_ticks  = poweron_r;
    cfg.boot_ticks     = boot_r;
    cfg.shutdown_ticks = shutdown_r;
    cfg.stop_ticks     = stop_r;
    cfg.duty_max       = duty_max_r;
    cfg.duty_min       = duty_min_r;
    cfg.divider        = divider_r;
    cfg.poweron_load   = wr_en && (idx == REG_POWERON);
    cfg.poweron_wdata  = cfg_pwdata[CFG_W-1:0];
  end

endmodule

[rtl/hps_core.sv]
module hps_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_en,
  input  hps_pkg::cmd_t    cmd,
  input  logic             act_level,
  input  logic             alarm_level,
  input  hps_pkg::cfg_t    cfg,
  output hps_pkg::result_t res_nxt
);
  import hps_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [TIMER_W-1:0] wait_r, wait_nxt, wait_dec;
  logic               wait_done;
  logic               shut_req_r, shut_req_nxt;
  logic               shut_can_r, shut_can_nxt;
  logic               wake_r, wake_nxt;
  logic               last_alarm_r, last_alarm_nxt;
  logic               last_act_r, last_act_nxt;
  logic               pin_alarm_r, pin_alarm_nxt;
  logic               pwr_r, pwr_nxt;
  logic               led1_r, led1_nxt;
  logic               led2_r, led2_nxt;
  logic               breath_r, breath_nxt;
  logic [DUTY_W-1:0]  duty_r, duty_nxt, duty_sum;
  logic [DUTY_W-1:0]  step_r, step_nxt;
  logic [DIV_W-1:0]   div_r, div_nxt;
  logic [DUTY_W-1:0]  duty_start;

  assign wait_dec   = wait_r - TIMER_W'(1);
  assign wait_done  = (wait_dec == '0);
  assign duty_sum   = duty_r + step_r;
  assign duty_start = (cfg.duty_max != '0) ? cfg.duty_max : cfg.duty_min;

  // Next state for the accepted item
  always_comb begin
    phase_nxt      = phase_r;
    wait_nxt       = wait_r;
    shut_req_nxt   = shut_req_r;
    shut_can_nxt   = shut_can_r;
    wake_nxt       = wake_r;
    last_alarm_nxt = last_alarm_r;
    last_act_nxt   = last_act_r;
    pin_alarm_nxt  = pin_alarm_r;
    pwr_nxt        = pwr_r;
    led1_nxt       = led1_r;
    led2_nxt       = led2_r;
    breath_nxt     = breath_r;
    duty_nxt       = duty_r;
    step_nxt       = step_r;
    div_nxt        = div_r;

    if (item_en) begin
      case (cmd)
        // Latch pin change events
        CMD_PIN: begin
          if (act_level != last_act_r || alarm_level != pin_alarm_r) begin
            last_act_nxt  = act_level;
            pin_alarm_nxt = alarm_level;
            last_alarm_nxt = alarm_level;
            if (!alarm_level && last_alarm_r) wake_nxt = 1'b1;
            shut_req_nxt = ~act_level;
            shut_can_nxt = act_level;
          end
        end
        // Advance the phase machine
        CMD_STEP: begin
          case (phase_r)
            PH_POWERON: begin
              pwr_nxt    = 1'b1;
              breath_nxt = 1'b0;
              duty_nxt   = cfg.duty_min;
              wait_nxt   = wait_dec;
              if (wait_done) begin
                phase_nxt = PH_BOOT;
                wait_nxt  = TIMER_W'(cfg.boot_ticks);
              end
            end
            PH_BOOT: begin
              breath_nxt = 1'b0;
              duty_nxt   = cfg.duty_min;
              led1_nxt   = 1'b1;
              led2_nxt   = 1'b1;
              pwr_nxt    = 1'b1;
              wait_nxt   = wait_dec;
              if (wait_done) begin
                phase_nxt    = PH_RUN;
                shut_req_nxt = 1'b0;
                shut_can_nxt = 1'b0;
              end
            end
            PH_RUN: begin
              breath_nxt = 1'b0;
              duty_nxt   = cfg.duty_min;
              pwr_nxt    = 1'b1;
              led2_nxt   = 1'b1;
              if (shut_req_r) begin
                phase_nxt    = PH_SHUTDOWN;
                wait_nxt     = TIMER_W'(cfg.shutdown_ticks);
                shut_req_nxt = 1'b0;
                shut_can_nxt = 1'b0;
              end
            end
            PH_SHUTDOWN: begin
              breath_nxt = 1'b0;
              duty_nxt   = cfg.duty_min;
              pwr_nxt    = 1'b1;
              wait_nxt   = wait_dec;
              if (wait_done) begin
                phase_nxt = PH_STOP;
                wait_nxt  = TIMER_W'(cfg.stop_ticks);
              end
              // A cancel overrides the move to stop; the counter still takes its decremented or reloaded value
              if (shut_can_r) begin
                phase_nxt    = PH_RUN;
                shut_can_nxt = 1'b0;
                shut_req_nxt = 1'b0;
                led2_nxt     = 1'b0;
              end
            end
            PH_STOP: begin
              pwr_nxt  = 1'b1;
              wait_nxt = wait_dec;
              if (wait_done) begin
                phase_nxt  = PH_OFF;
                wake_nxt   = 1'b0;
                duty_nxt   = duty_start;
                breath_nxt = 1'b1;
              end
            end
            PH_OFF: begin
              led1_nxt = 1'b0;
              pwr_nxt  = 1'b0;
              if (wake_r) begin
                phase_nxt = PH_BOOT;
                wait_nxt  = TIMER_W'(cfg.boot_ticks);
                wake_nxt  = 1'b0;
              end
            end
            default: ;
          endcase
        end
        // Advance the breathing duty
        CMD_TICK: begin
          if (breath_r) begin
            if (div_r == cfg.divider) begin
              div_nxt  = DIV_W'(1);
              duty_nxt = duty_sum;
              if (duty_sum > cfg.duty_max || duty_sum < cfg.duty_min) begin
                step_nxt = DUTY_W'(0) - step_r;
              end
            end else begin
              div_nxt = div_r + DIV_W'(1);
            end
          end
        end
        default: ;
      endcase
    end else if (cfg.poweron_load && phase_r == PH_POWERON) begin
      // Reload the running power-on wait
      wait_nxt = TIMER_W'(cfg.poweron_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_POWERON;
      wait_r       <= TIMER_W'(RST_POWERON);
      shut_req_r   <= 1'b0;
      shut_can_r   <= 1'b0;
      wake_r       <= 1'b0;
      last_alarm_r <= 1'b1;
      last_act_r   <= 1'b1;
      pin_alarm_r  <= 1'b1;
      pwr_r        <= 1'b1;
      led1_r       <= 1'b0;
      led2_r       <= 1'b0;
      breath_r     <= 1'b0;
      duty_r       <= '0;
      step_r       <= DUTY_W'(1);
      div_r        <= '0;
    end else begin
      phase_r      <= phase_nxt;
      wait_r       <= wait_nxt;
      shut_req_r   <= shut_req_nxt;
      shut_can_r   <= shut_can_nxt;
      wake_r       <= wake_nxt;
      last_alarm_r <= last_alarm_nxt;
      last_act_r   <= last_act_nxt;
      pin_alarm_r  <= pin_alarm_nxt;
      pwr_r        <= pwr_nxt;
      led1_r       <= led1_nxt;
      led2_r       <= led2_nxt;
      breath_r     <= breath_nxt;
      duty_r       <= duty_nxt;
      step_r       <= step_nxt;
      div_r        <= div_nxt;
    end
  end

  // Outputs as they stand after this item
  always_comb begin
    res_nxt.phase        = phase_nxt;
    res_nxt.duty         = duty_nxt;
    res_nxt.breathing    = breath_nxt;
    res_nxt.led_two      = led2_nxt;
    res_nxt.led_one      = led1_nxt;
    res_nxt.power_enable = pwr_nxt;
  end

endmodule

[rtl/host_power_sequencer.sv]
// Host power sequencer.
// Input channel in_*: one item per handshake. in_tuser[1:0] is the command
// (pin sample, sequencer step, PWM tick; the fourth code reports only).
// in_tdata carries the activity LED and alarm pin levels for pin samples.
// Output channel out_*: exactly one result item per input item, carrying
// power enable, both LEDs, breathing flag, breathing duty and phase.
// The result of an item accepted at an edge is valid from that edge on.
// One item per cycle is taken unless the receiver stalls; the state update and
// result come from one pass of logic between the state and result registers.
// When the receiver stalls, the result register holds; in_tready stays high
// while the held result is taken in the same cycle, so a new item can follow
// without a bubble, and drops only while a result waits untaken.
// Reset (rst_n low, synchronous) loads the register defaults, puts the
// sequencer in the power-on wait with power enabled and empties the result
// register. The cfg_* port is APB style, registers at byte address 4*index,
// always ready; write only while no item is in flight.
module host_power_sequencer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // activity_led_level, alarm_level
  input  logic [1:0]                 in_tuser,   // command
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [15:0]                out_tdata,  // power_enable, led_one, led_two,
                                                 // breathing_on, breath_duty[7:0],
                                                 // phase[2:0]
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [hps_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [hps_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [hps_pkg::DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import hps_pkg::*;

  cfg_t    cfg;
  result_t res_nxt;
  result_t res_r;
  logic    out_valid_r;
  logic    accept;

  assign in_tready = ~out_valid_r | out_tready;
  assign accept    = in_tvalid & in_tready;

  hps_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  hps_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_en     (accept),
    .cmd         (cmd_t'(in_tuser)),
    .act_level   (in_tdata[0]),
    .alarm_level (in_tdata[1]),
    .cfg         (cfg),
    .res_nxt     (res_nxt)
  );

  // Result register valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Capture result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r.phase, res_r.duty, res_r.breathing,
                       res_r.led_two, res_r.led_one, res_r.power_enable};

endmodule

[sim/tb_host_power_sequencer.sv]
`timescale 1ns / 100ps

module tb_host_power_sequencer;
  import hps_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned MAX_PRINTS = 40;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [7:0]        in_tdata;   // activity_led_level, alarm_level
  logic [1:0]        in_tuser;   // command
  logic              out_tvalid;
  logic              out_tready;
  logic [15:0]       out_tdata;  // power_enable, led_one, led_two, breathing_on,
                                 // breath_duty[7:0], phase[2:0]
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned err_count;
  int unsigned cycle_cnt;
  result_t     pending_outputs[$];

  // Shadow copy of the configuration registers
  logic [CFG_W-1:0]  cfg_poweron, cfg_boot, cfg_shutdown, cfg_stop;
  logic [DUTY_W-1:0] cfg_duty_max, cfg_duty_min;
  logic [DIV_W-1:0]  cfg_divider;

  // Shadow copy of the sequencer state
  phase_t            seq_phase;
  logic [TIMER_W-1:0] wait_cnt;
  logic              shut_req, shut_cancel, wake_req;
  logic              alarm_edge_ref, act_sample, alarm_sample;
  logic              pwr_en, led1, led2, breathing;
  logic [DUTY_W-1:0] duty, duty_inc;
  logic [DIV_W-1:0]  div_cnt;

  host_power_sequencer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Stall the result channel at the current rate
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Load the shadow state with the block's reset values
  task automatic reset_shadow();
    cfg_poweron    = RST_POWERON;
    cfg_boot       = RST_BOOT;
    cfg_shutdown   = RST_SHUTDOWN;
    cfg_stop       = RST_STOP;
    cfg_duty_max   = RST_DUTY_MAX;
    cfg_duty_min   = RST_DUTY_MIN;
    cfg_divider    = RST_DIVIDER;
    seq_phase      = PH_POWERON;
    wait_cnt       = RST_POWERON;
    shut_req       = 1'b0;
    shut_cancel    = 1'b0;
    wake_req       = 1'b0;
    alarm_edge_ref = 1'b1;
    act_sample     = 1'b1;
    alarm_sample   = 1'b1;
    pwr_en         = 1'b1;
    led1           = 1'b0;
    led2           = 1'b0;
    breathing      = 1'b0;
    duty           = '0;
    duty_inc       = 8'd1;
    div_cnt        = '0;
  endtask

  // Apply one item to the shadow state and return the outputs after it
  function automatic result_t advance_sequencer(cmd_t cmd, logic act, logic alarm);
    result_t r;
    case (cmd)
      CMD_PIN: begin
        if (act != act_sample || alarm != alarm_sample) begin
          act_sample   = act;
          alarm_sample = alarm;
          if (alarm && !alarm_edge_ref) alarm_edge_ref = 1'b1;
          if (!alarm && alarm_edge_ref) begin
            alarm_edge_ref = 1'b0;
            wake_req       = 1'b1;
          end
          shut_req    = !act;
          shut_cancel = act;
        end
      end
      CMD_STEP: begin
        case (seq_phase)
          PH_POWERON: begin
            pwr_en    = 1'b1;
            breathing = 1'b0;
            duty      = cfg_duty_min;
            wait_cnt  = wait_cnt - 1'b1;
            if (wait_cnt == '0) begin
              seq_phase = PH_BOOT;
              wait_cnt  = cfg_boot;
            end
          end
          PH_BOOT: begin
            breathing = 1'b0;
            duty      = cfg_duty_min;
            led1      = 1'b1;
            led2      = 1'b1;
            pwr_en    = 1'b1;
            // counter is left at zero when the boot wait ends
            wait_cnt  = wait_cnt - 1'b1;
            if (wait_cnt == '0) begin
              seq_phase   = PH_RUN;
              shut_req    = 1'b0;
              shut_cancel = 1'b0;
            end
          end
          PH_RUN: begin
            breathing = 1'b0;
            duty      = cfg_duty_min;
            pwr_en    = 1'b1;
            led2      = 1'b1;
            if (shut_req) begin
              seq_phase   = PH_SHUTDOWN;
              wait_cnt    = cfg_shutdown;
              shut_req    = 1'b0;
              shut_cancel = 1'b0;
            end
          end
          PH_SHUTDOWN: begin
            breathing = 1'b0;
            duty      = cfg_duty_min;
            pwr_en    = 1'b1;
            wait_cnt  = wait_cnt - 1'b1;
            if (wait_cnt == '0) begin
              seq_phase = PH_STOP;
              wait_cnt  = cfg_stop;
            end
            // a cancel wins over the end of the wait
            if (shut_cancel) begin
              seq_phase   = PH_RUN;
              shut_cancel = 1'b0;
              shut_req    = 1'b0;
              led2        = 1'b0;
            end
          end
          PH_STOP: begin
            pwr_en   = 1'b1;
            wait_cnt = wait_cnt - 1'b1;
            if (wait_cnt == '0) begin
              seq_phase = PH_OFF;
              wake_req  = 1'b0;
              duty      = (cfg_duty_max != '0) ? cfg_duty_max : cfg_duty_min;
              breathing = 1'b1;
            end
          end
          PH_OFF: begin
            led1   = 1'b0;
            pwr_en = 1'b0;
            if (wake_req) begin
              seq_phase = PH_BOOT;
              wait_cnt  = cfg_boot;
              wake_req  = 1'b0;
            end
          end
          default: ;
        endcase
      end
      CMD_TICK: begin
        if (breathing) begin
          if (div_cnt == cfg_divider) begin
            div_cnt = '0;
            duty    = duty + duty_inc;
            if (duty > cfg_duty_max || duty < cfg_duty_min) duty_inc = -duty_inc;
          end
          div_cnt = div_cnt + 1'b1;
        end
      end
      default: ;
    endcase
    r.phase        = seq_phase;
    r.duty         = duty;
    r.breathing    = breathing;
    r.led_two      = led2;
    r.led_one      = led1;
    r.power_enable = pwr_en;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (err_count < MAX_PRINTS)
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_cnt, what, got, want);
    err_count++;
  endtask

  // Compare each accepted result with the oldest expected one
  always @(negedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[14:0]);
      if (pending_outputs.size() == 0) begin
        report_mismatch("unexpected result, tdata", int'(out_tdata), 0);
      end else begin
        want = pending_outputs.pop_front();
        if (got.power_enable != want.power_enable)
          report_mismatch("power_enable", int'(got.power_enable), int'(want.power_enable));
        if (got.led_one != want.led_one)
          report_mismatch("led_one", int'(got.led_one), int'(want.led_one));
        if (got.led_two != want.led_two)
          report_mismatch("led_two", int'(got.led_two), int'(want.led_two));
        if (got.breathing != want.breathing)
          report_mismatch("breathing_on", int'(got.breathing), int'(want.breathing));
        if (got.duty != want.duty)
          report_mismatch("breath_duty", int'(got.duty), int'(want.duty));
        if (got.phase != want.phase)
          report_mismatch("phase", int'(got.phase), int'(want.phase));
      end
    end
  end

  // Send one item, with a random gap before it, and queue its outputs
  task automatic send_item(input cmd_t cmd, input logic act, input logic alarm);
    logic rdy;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'b0, alarm, act};
    forever begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
      if (rdy) break;
    end
    pending_outputs.push_back(advance_sequencer(cmd, act, alarm));
  endtask

  // Drop valid and wait until every queued result has come out
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register through the setup and access cycles
  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_POWERON: begin
        cfg_poweron = value[CFG_W-1:0];
        if (seq_phase == PH_POWERON) wait_cnt = value[CFG_W-1:0];
      end
      REG_BOOT:     cfg_boot     = value[CFG_W-1:0];
      REG_SHUTDOWN: cfg_shutdown = value[CFG_W-1:0];
      REG_STOP:     cfg_stop     = value[CFG_W-1:0];
      REG_DUTY_MAX: cfg_duty_max = value[DUTY_W-1:0];
      REG_DUTY_MIN: cfg_duty_min = value[DUTY_W-1:0];
      REG_DIVIDER:  cfg_divider  = value[DIV_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
      3: begin send_idle_pct = 23; recv_stall_pct = 23; end
      default: begin send_idle_pct = 0; recv_stall_pct = 0; end
    endcase
  endtask

  // Outputs at reset values: unknown command, idle tick, unchanged pins, one step
  task automatic test_reset_outputs();
    send_item(CMD_NOP, 1'b0, 1'b0);
    send_item(CMD_TICK, 1'b1, 1'b1);
    send_item(CMD_PIN, 1'b1, 1'b1);
    send_item(CMD_STEP, 1'b0, 1'b0);
    wait_for_drain();
  endtask

  // Zero power-on wait wraps the counter; rewrites reload it in the power-on phase
  task automatic test_poweron_reload();
    write_reg(REG_POWERON, '0);
    send_item(CMD_STEP, 1'b0, 1'b0);
    wait_for_drain();
    write_reg(REG_POWERON, 32'hFF_FFFF);
    write_reg(REG_BOOT, 32'hFF_FFFF);
    write_reg(REG_SHUTDOWN, 32'hFF_FFFF);
    write_reg(REG_STOP, 32'hFF_FFFF);
    send_item(CMD_STEP, 1'b1, 1'b0);
    wait_for_drain();
  endtask

  // Walk every phase: power-on wait of two steps, others of one, a cancelled shutdown, a wake
  task automatic test_phase_walk();
    write_reg(REG_POWERON, 32'd2);
    write_reg(REG_BOOT, 32'd1);
    write_reg(REG_SHUTDOWN, 32'd1);
    write_reg(REG_STOP, 32'd1);
    write_reg(REG_DUTY_MAX, '0);
    write_reg(REG_DUTY_MIN, 32'd254);
    write_reg(REG_DIVIDER, '0);
    write_reg(REG_NONE, 32'hFFFF_FFFF);
    send_item(CMD_STEP, 1'b1, 1'b1);
    send_item(CMD_STEP, 1'b1, 1'b1);
    send_item(CMD_STEP, 1'b1, 1'b1);
    send_item(CMD_PIN, 1'b0, 1'b1);
    send_item(CMD_STEP, 1'b0, 1'b1);
    send_item(CMD_PIN, 1'b1, 1'b1);
    send_item(CMD_STEP, 1'b1, 1'b1);
    send_item(CMD_PIN, 1'b0, 1'b1);
    send_item(CMD_STEP, 1'b0, 1'b1);
    send_item(CMD_STEP, 1'b0, 1'b1);
    send_item(CMD_STEP, 1'b0, 1'b1);
    send_item(CMD_TICK, 1'b0, 1'b1);
    send_item(CMD_PIN, 1'b0, 1'b0);
    send_item(CMD_PIN, 1'b0, 1'b1);
    send_item(CMD_STEP, 1'b0, 1'b1);
    send_item(CMD_TICK, 1'b1, 1'b0);
    send_item(CMD_STEP, 1'b1, 1'b0);
    wait_for_drain();
  endtask

  // Random traffic over several settings and idling modes
  task automatic test_random_traffic();
    int unsigned dmax;
    int unsigned dmin;
    int unsigned r;
    for (int p = 0; p < 8; p++) begin
      dmax = (p == 2) ? 254 : (p == 5) ? 1 : $urandom_range(2, 254);
      dmin = dmax - $urandom_range(0, (dmax < 3) ? dmax : 3);
      write_reg(REG_POWERON, $urandom_range(1, 5));
      write_reg(REG_BOOT, $urandom_range(1, 5));
      write_reg(REG_SHUTDOWN, $urandom_range(1, 5));
      write_reg(REG_STOP, $urandom_range(1, 5));
      write_reg(REG_DUTY_MAX, dmax);
      write_reg(REG_DUTY_MIN, dmin);
      // keep the divider non-decreasing so its counter never overshoots it
      write_reg(REG_DIVIDER, (p == 7) ? 32'hFFFF : 2 + p / 2);
      set_idling(p % 4);
      repeat (205) begin
        r = $urandom_range(99);
        if (r < 40)
          send_item(CMD_STEP, 1'($urandom_range(1)), 1'($urandom_range(1)));
        else if (r < 75)
          send_item(CMD_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)));
        else if (r < 95)
          send_item(CMD_PIN, 1'($urandom_range(1)), 1'($urandom_range(1)));
        else
          send_item(CMD_NOP, 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
      wait_for_drain();
    end
  endtask

  // End the run if it takes far longer than it should
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    err_count      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= CMD_NOP;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    reset_shadow();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_outputs();
    test_poweron_reload();
    test_phase_walk();
    test_random_traffic();

    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
